// ----- rtl/ple_pkg.sv -----
package ple_pkg;

   // Default list capacity in elements
   localparam int CAPACITY_DEFAULT = 256;

   // Operation codes
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_MAX    = 3'd2;
   localparam logic [2:0] OP_EVENS  = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   // Status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   // Request transaction
   typedef struct packed {
      logic [2:0]         op;
      logic [15:0]        position;
      logic signed [31:0] value;
   } req_type;

   // Response transaction
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] value_out;
      logic [8:0]         size;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic init;    // set up pointers for the element walk
      logic read;    // read one element and step the pointer
      logic finish;  // commit count, final write and response
   } ctrl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan;    // operation walks stored elements
      logic last;    // read pointer is at the final element
   } dp_stat_type;

endpackage

// ----- rtl/ple_ctrl.sv -----
module ple_ctrl import ple_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic         req_load,
   output ctrl_cmd_type cmd,
   input  dp_stat_type  stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_SCAN,
      S_DRAIN,
      S_FIN
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   // Handshake and command decode
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE);
   assign req_load   = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.init   = (state_ff == S_PREP);
   assign cmd.read   = (state_ff == S_SCAN) && stat.scan;
   assign cmd.finish = (state_ff == S_FIN) && slot_free;

   // Sequencer and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_load) begin
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               state_ff <= S_SCAN;
            end
            S_SCAN: begin
               if (!stat.scan) begin
                  state_ff <= S_FIN;
               end else if (stat.last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTH
   a_finish_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("response valid not raised after finish");
   a_fin_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && !slot_free) |=> (state_ff == S_FIN))
      else $error("left finish state while response slot busy");
   a_last_drains: assert property (@(posedge clock) disable iff (reset)
      (cmd.read && stat.last) |=> (state_ff == S_DRAIN))
      else $error("walk did not end after last read");
`endif

endmodule

// ----- rtl/ple_dpath.sv -----
module ple_dpath import ple_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_load,
   input  req_type      req_data,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   output rsp_type      rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   // Element store
   logic [31:0] mem [CAPACITY];

   // Latched request
   logic [2:0]         op_ff;
   logic [15:0]        pos_ff;
   logic signed [31:0] val_ff;

   // List and walk state
   logic [CW-1:0]      count_ff;
   logic [AW-1:0]      rp_ff;
   logic [CW-1:0]      k_ff;
   logic               rd_vld_ff;
   logic               first_ff;
   logic [AW-1:0]      rd_addr_ff;
   logic [31:0]        rd_data_ff;
   logic signed [31:0] best_ff;
   rsp_type            rsp_ff;

   logic          is_ins, is_rem, is_max, is_evn, is_clr;
   logic          full, empty, pos_ge;
   logic [AW-1:0] last_addr, ins_addr, start_addr;
   logic [1:0]    status;
   logic [CW-1:0] new_count;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic          take_best;

   // Operation decode and checks
   assign is_ins    = (op_ff == OP_INSERT);
   assign is_rem    = (op_ff == OP_REMOVE);
   assign is_max    = (op_ff == OP_MAX);
   assign is_evn    = (op_ff == OP_EVENS);
   assign is_clr    = (op_ff == OP_CLEAR);
   assign full      = (count_ff == CW'(CAPACITY));
   assign empty     = (count_ff == '0);
   assign pos_ge    = (pos_ff >= 16'(count_ff));
   assign last_addr = AW'(count_ff - CW'(1));
   assign ins_addr  = pos_ge ? AW'(count_ff) : AW'(pos_ff);

   always_comb begin
      status = ST_OK;
      if (is_ins) begin
         if (full) status = ST_FULL;
      end else if (is_rem) begin
         if (empty) status = ST_EMPTY;
         else if (pos_ge) status = ST_RANGE;
      end else if (is_max || is_evn || is_clr) begin
         if (empty) status = ST_EMPTY;
      end
   end

   // Walk range: insert shifts downward from the tail, others walk upward
   assign stat.scan = (status == ST_OK) &&
                      ((is_ins && !pos_ge) || is_rem || is_max || is_evn);
   assign stat.last = is_ins ? (rp_ff == ins_addr) : (rp_ff == last_addr);
   assign start_addr = is_ins ? last_addr : (is_rem ? AW'(pos_ff) : '0);

   // Count after the operation
   always_comb begin
      new_count = count_ff;
      if (status == ST_OK) begin
         if (is_ins)      new_count = count_ff + CW'(1);
         else if (is_rem) new_count = count_ff - CW'(1);
         else if (is_evn) new_count = k_ff;
         else if (is_clr) new_count = '0;
      end
      if (is_clr) new_count = '0;
   end

   // Write port: element moves during the walk, inserted value at finish
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = rd_addr_ff;
      wr_data = rd_data_ff;
      if (rd_vld_ff) begin
         if (is_ins) begin
            wr_en   = 1'b1;
            wr_addr = rd_addr_ff + AW'(1);
         end else if (is_rem && !first_ff) begin
            wr_en   = 1'b1;
            wr_addr = rd_addr_ff - AW'(1);
         end else if (is_evn && rd_data_ff[0]) begin
            wr_en   = 1'b1;
            wr_addr = AW'(k_ff);
         end
      end else if (cmd.finish && is_ins && status == ST_OK) begin
         wr_en   = 1'b1;
         wr_addr = ins_addr;
         wr_data = val_ff;
      end
   end

   // Remove captures the first element; maximum keeps the largest seen
   assign take_best = rd_vld_ff &&
                      ((is_rem && first_ff) ||
                       (is_max && (first_ff || $signed(rd_data_ff) > best_ff)));

   // Store access
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[rp_ff];
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_load) begin
         op_ff  <= req_data.op;
         pos_ff <= req_data.position;
         val_ff <= req_data.value;
      end
      if (cmd.init) begin
         rp_ff <= start_addr;
      end else if (cmd.read) begin
         rp_ff <= is_ins ? rp_ff - AW'(1) : rp_ff + AW'(1);
      end
      if (cmd.read) begin
         rd_addr_ff <= rp_ff;
      end
      if (take_best) begin
         best_ff <= $signed(rd_data_ff);
      end
      if (cmd.finish) begin
         rsp_ff.status    <= status;
         rsp_ff.value_out <= (status == ST_OK && (is_rem || is_max)) ? best_ff : '0;
         rsp_ff.size      <= 9'(new_count);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         k_ff      <= '0;
         rd_vld_ff <= 1'b0;
         first_ff  <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.read;
         if (cmd.init) begin
            k_ff     <= '0;
            first_ff <= 1'b1;
         end else begin
            if (rd_vld_ff) first_ff <= 1'b0;
            if (rd_vld_ff && is_evn && rd_data_ff[0]) k_ff <= k_ff + CW'(1);
         end
         if (cmd.finish) begin
            count_ff <= new_count;
         end
      end
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");
   a_kept_bound: assert property (@(posedge clock) disable iff (reset)
      k_ff <= count_ff)
      else $error("kept count above element count");
   a_drained: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !rd_vld_ff)
      else $error("finish while a read is still in flight");
`endif

endmodule

// ----- rtl/positional_list_engine.sv -----
// Positional list engine: bounded ordered list of signed 32-bit values.
// Request channel (req_valid/req_ready/req_data) carries one operation per
// transaction: insert, remove at position, maximum, remove evens or clear.
// Response channel (rsp_valid/rsp_ready/rsp_data) returns exactly one
// transaction per request: status, value and the new list size.
// Each request walks n elements, where n is the shifted tail for insert and
// remove and the whole list for maximum and remove evens; operations that
// walk nothing (clear, append, refused or unused codes) skip the walk. The
// walk reads the element store one entry per cycle through its single
// read port.
// One request is processed at a time; the next is accepted as soon as the
// previous one has been committed, even if its response is still waiting.
// A stalled receiver holds the response register; a finished operation
// then waits to commit until the response slot frees.
// Reset empties the list at once; store contents are not cleared.
module positional_list_engine import ple_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;
   logic         req_load;

   // Sequencer
   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .req_load  (req_load),
      .cmd       (cmd),
      .stat      (stat)
   );

   // Element store and arithmetic
   ple_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_load (req_load),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
